/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("Assertion failed: invariant does not hold.");

// When the trigger holds, the consequence holds at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("Assertion failed: expected next-cycle behavior missing.");

`endif

/* hdl/bdq_pkg.sv */
`default_nettype none

package bdq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int EXT_W       = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef logic [VALUE_WIDTH-1:0] entry_t;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } cell_ctl_t;

    function automatic entry_t to_entry(input logic [31:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_entry(input entry_t e);
        logic [EXT_W-1:0] t;
        t = EXT_W'(signed'(e));
        return t[31:0];
    endfunction

    function automatic logic [4:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] t;
        t = (CNT_W + 5)'(c);
        return t[4:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/bdq_cell.sv */
`default_nettype none

module bdq_cell
    import bdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    push_data,
    input  entry_t    left_data,
    input  logic      left_occ,
    input  entry_t    right_data,
    input  logic      right_occ,
    output entry_t    data,
    output logic      occ
);

    entry_t data_reg;
    entry_t data_next;
    logic   occ_reg;
    logic   occ_next;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctl.push_front)
        begin
            data_next = left_data;
            occ_next  = left_occ;
        end
        else if (ctl.push_back)
        begin
            if (!occ_reg && left_occ)
            begin
                data_next = push_data;
                occ_next  = 1'b1;
            end
        end
        else if (ctl.pop_front)
        begin
            data_next = right_data;
            occ_next  = right_occ;
        end
        else if (ctl.pop_back)
        begin
            if (occ_reg && !right_occ)
            begin
                occ_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule

`default_nettype wire

/* hdl/bdq_chain.sv */
`default_nettype none

`include "assert_macros.svh"

module bdq_chain
    import bdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctl_t           ctl,
    input  entry_t              push_data,
    output entry_t              front_data,
    output entry_t              back_data,
    output logic [CAPACITY-1:0] occ
);

    entry_t              cell_data [CAPACITY];
    logic [CAPACITY-1:0] tail;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t l_data;
        logic   l_occ;
        entry_t r_data;
        logic   r_occ;

        if (i == 0)
        begin : g_first
            assign l_data = push_data;
            assign l_occ  = 1'b1;
        end
        else
        begin : g_inner_l
            assign l_data = cell_data[i-1];
            assign l_occ  = occ[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_data = push_data;
            assign r_occ  = 1'b0;
        end
        else
        begin : g_inner_r
            assign r_data = cell_data[i+1];
            assign r_occ  = occ[i+1];
        end

        bdq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .push_data  (push_data),
            .left_data  (l_data),
            .left_occ   (l_occ),
            .right_data (r_data),
            .right_occ  (r_occ),
            .data       (cell_data[i]),
            .occ        (occ[i])
        );

        assign tail[i] = occ[i] && !r_occ;
    end

    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_data = back_data | (cell_data[i] & {VALUE_WIDTH{tail[i]}});
        end
    end

    assign front_data = cell_data[0];

    // Occupied cells always form one run starting at the front.
    `ASSERT_ALWAYS(a_occ_contiguous, clk, rst_n,
        (occ & (occ + CAPACITY'(1))) == '0)
    `ASSERT_ALWAYS(a_single_tail, clk, rst_n, $onehot0(tail))

endmodule

`default_nettype wire

/* hdl/bounded_deque.sv */
// Bounded double-ended queue of signed values, held in a row of cells.
// Request channel: req_valid/req_ready carry func (0 push front, 1 push back,
// 2 pop front, 3 pop back) and item_value, which only pushes use.
// Response channel: rsp_valid/rsp_ready carry status (0 ok, 1 overflow,
// 2 empty), popped_value and fill_count after the operation.
// Every item gives exactly one response, in the cycle after it is accepted.
// One item is taken per cycle while responses are taken: the cell row and the
// response register load together; it refills in the cycle it is drained.
// The front entry always sits in the first cell; a push at the front or a
// pop at the front shifts every cell by one place, while back operations
// touch only the last occupied cell (pop) or the first free cell (push).
// A push while full is refused and leaves the queue unchanged; a pop while
// empty is refused likewise, and popped_value is zero unless a pop succeeds.
// Reset empties the queue and drops any pending response.
// While the receiver stalls the response holds, and req_ready stays low
// until the response is taken, so at most one response is ever pending.
`default_nettype none

`include "assert_macros.svh"

module bounded_deque
    import bdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] item_value,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [1:0]         status,
    output logic signed [31:0] popped_value,
    output logic [4:0]         fill_count
);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                rsp_valid_reg;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [31:0]         popped_reg;
    logic [31:0]         popped_next;
    logic [4:0]          fill_reg;
    logic                accept;
    logic                full;
    logic                empty;
    cell_ctl_t           ctl;
    entry_t              front_data;
    entry_t              back_data;
    logic [CAPACITY-1:0] occ;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        ctl         = '0;
        status_next = ST_OK;
        popped_next = '0;
        count_next  = count_reg;
        case (func)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ctl.push_front = accept && (func == OP_PUSH_FRONT);
                    ctl.push_back  = accept && (func == OP_PUSH_BACK);
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctl.pop_front = accept && (func == OP_POP_FRONT);
                    ctl.pop_back  = accept && (func == OP_POP_BACK);
                    popped_next   = (func == OP_POP_FRONT) ? from_entry(front_data)
                                                           : from_entry(back_data);
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    bdq_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .push_data  (to_entry(item_value)),
        .front_data (front_data),
        .back_data  (back_data),
        .occ        (occ)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            fill_reg   <= count_field(count_next);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign popped_value = signed'(popped_reg);
    assign fill_count   = fill_reg;

    // The occupied run in the cell row always matches the fill count.
    `ASSERT_ALWAYS(a_occ_matches_count, clk, rst_n,
        $countones(occ) == int'(count_reg))
    `ASSERT_ALWAYS(a_count_bounded, clk, rst_n, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_NEXT(a_refused_pop_zero, clk, rst_n,
        accept && (func == OP_POP_FRONT || func == OP_POP_BACK) && empty,
        popped_reg == '0 && status_reg == ST_EMPTY)
    `ASSERT_NEXT(a_accept_gives_rsp, clk, rst_n, accept, rsp_valid_reg)

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
    import bdq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [4:0]         fill;
    } deque_result_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [1:0]         func = OP_PUSH_BACK;
    logic signed [31:0] item_value = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [4:0]         fill_count;

    deque_result_t      pending_results[$];
    logic signed [31:0] model_slots[CAPACITY];
    int                 model_head = 0;
    int                 model_count = 0;
    int                 error_count = 0;
    int                 sent_count = 0;
    int                 burst_left = 0;
    int                 cycle_count = 0;
    int                 rx_phase_left = 0;
    rx_mode_e           rx_mode = RX_ALWAYS;

    bounded_deque dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .func         (func),
        .item_value   (item_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .popped_value (popped_value),
        .fill_count   (fill_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(20, 200);
        end
        else
        begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= ($urandom_range(0, 1) != 0);
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 5) == 0);
            default:     rsp_ready <= (cycle_count % 4) != 3;
        endcase
    end

    function automatic deque_result_t apply_operation(input logic [1:0] op,
                                                      input logic signed [31:0] v);
        deque_result_t r;
        int            slot;
        r.status = ST_OK;
        r.value = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (model_count >= CAPACITY)
            begin
                r.status = ST_OVERFLOW;
            end
            else
            begin
                if (op == OP_PUSH_FRONT)
                begin
                    model_head = (model_head + CAPACITY - 1) % CAPACITY;
                    slot = model_head;
                end
                else
                begin
                    slot = (model_head + model_count) % CAPACITY;
                end
                model_slots[slot] = v;
                model_count++;
            end
        end
        else if (model_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else if (op == OP_POP_FRONT)
        begin
            r.value = model_slots[model_head];
            model_head = (model_head + 1) % CAPACITY;
            model_count--;
        end
        else
        begin
            r.value = model_slots[(model_head + model_count - 1) % CAPACITY];
            model_count--;
        end
        r.fill = 5'(model_count);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("mismatch at cycle %0d on %s: expected %0d, got %0d",
                 cycle_count, field, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected response status", -1, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", want.status, status);
                if (popped_value !== want.value)
                    report_mismatch("popped_value", want.value, popped_value);
                if (fill_count !== want.fill)
                    report_mismatch("fill_count", want.fill, fill_count);
            end
        end
        if (rst_n && req_valid && req_ready)
            pending_results.push_back(apply_operation(func, item_value));
    end

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic signed [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        func <= op;
        item_value <= v;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_count++;
    endtask

    // The last accepted item is queued at the same edge, so the check waits for
    // the next edge before it starts.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_pops();
        send_item(OP_POP_FRONT, random_value());
        send_item(OP_POP_BACK, random_value());
    endtask

    task automatic test_value_extremes();
        send_item(OP_PUSH_BACK, 32'sh7fffffff);
        send_item(OP_PUSH_FRONT, 32'sh80000000);
        send_item(OP_PUSH_BACK, '0);
        send_item(OP_PUSH_FRONT, -32'sd1);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_POP_BACK, -32'sd1);
        send_item(OP_POP_FRONT, 32'sh7fffffff);
        send_item(OP_POP_BACK, 32'sh80000000);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < CAPACITY; i++)
            send_item((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_value());
        send_item(OP_PUSH_FRONT, random_value());
        send_item(OP_PUSH_BACK, random_value());
    endtask

    // Runs of pushes and runs of pops walk the fill level between the empty and
    // the full queue, so both refusals and pointer wrap occur often.
    task automatic test_random_traffic(input int n);
        int         target;
        int         kind;
        int         run;
        logic [1:0] op;
        target = sent_count + n;
        while (sent_count < target)
        begin
            kind = $urandom_range(0, 9);
            run = $urandom_range(1, 20);
            for (int i = 0; i < run; i++)
            begin
                if (kind < 3)
                    op = ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else if (kind < 6)
                    op = ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
                else
                    op = 2'($urandom_range(0, 3));
                send_item(op, random_value());
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pops();
        test_value_extremes();
        test_full_queue();
        test_random_traffic(475);
        wait_for_results();
        test_random_traffic(475);
        wait_for_results();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
